// File: design/rccc_pkg.sv
// ----------------------------------------------------------------------------
// rccc_pkg: shared types and helpers for the row convex connected check
// Holds the fixed field widths, the status codes and the bit-vector helper
// functions used by the load front and the check back end.
// ----------------------------------------------------------------------------
package rccc_pkg;

  localparam int ROW_W  = 32;
  localparam int COLS_W = 6;
  localparam int KEPT_W = 6;

  localparam logic [COLS_W-1:0] COLS_RESET = 6'd32;
  localparam logic [KEPT_W-1:0] KEPT_MAX   = '1;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_NOT_CONVEX    = 3'd1,
    ST_NOT_CONNECTED = 3'd2,
    ST_ALL_EMPTY     = 3'd3,
    ST_TOO_MANY_ROWS = 3'd4
  } status_e;

  // Number of set bits, counted per byte and then summed.
  function automatic logic [KEPT_W-1:0] popcount(input logic [ROW_W-1:0] v);
    logic [3:0] byte_cnt [4];
    logic [KEPT_W-1:0] total;
    for (int b = 0; b < 4; b++) begin
      byte_cnt[b] = '0;
      for (int k = 0; k < 8; k++) begin
        byte_cnt[b] = byte_cnt[b] + 4'(v[8*b+k]);
      end
    end
    total = KEPT_W'(byte_cnt[0]) + KEPT_W'(byte_cnt[1]) +
            KEPT_W'(byte_cnt[2]) + KEPT_W'(byte_cnt[3]);
    return total;
  endfunction

  // Sets every bit at or below the highest set bit.
  function automatic logic [ROW_W-1:0] smear_down(input logic [ROW_W-1:0] v);
    logic [ROW_W-1:0] s;
    s = v;
    s = s | (s >> 1);
    s = s | (s >> 2);
    s = s | (s >> 4);
    s = s | (s >> 8);
    s = s | (s >> 16);
    return s;
  endfunction

endpackage

// File: design/rccc_in_if.sv
// ----------------------------------------------------------------------------
// rccc_in_if: row input channel
// Valid/ready channel that carries one matrix row and its last-row flag.
// ----------------------------------------------------------------------------
interface rccc_in_if;
  logic                       valid;
  logic                       ready;
  logic [rccc_pkg::ROW_W-1:0] row_bits;
  logic                       last_row;

  modport source (output valid, output row_bits, output last_row, input ready);
  modport sink   (input valid, input row_bits, input last_row, output ready);
endinterface

// File: design/rccc_out_if.sv
// ----------------------------------------------------------------------------
// rccc_out_if: check result channel
// Valid/ready channel that carries the status and the kept row and column
// counts of one checked matrix.
// ----------------------------------------------------------------------------
interface rccc_out_if;
  logic                        valid;
  logic                        ready;
  rccc_pkg::status_e           status;
  logic [rccc_pkg::KEPT_W-1:0] kept_rows;
  logic [rccc_pkg::KEPT_W-1:0] kept_cols;

  modport source (output valid, output status, output kept_rows, output kept_cols,
                  input ready);
  modport sink   (input valid, input status, input kept_rows, input kept_cols,
                  output ready);
endinterface

// File: design/row_convex_connected_check_top.sv
// ----------------------------------------------------------------------------
// row_convex_connected_check_top: connected row convex check of a 0/1 matrix
// Loads the matrix one row per item and, after the last row, reports whether
// the reduced matrix is row convex and connected.
// ----------------------------------------------------------------------------
// Throughput: one row item per cycle while a matrix loads.
// Sequence: once a matrix's last row is accepted, the back end takes the job,
//   makes N store reads, N being the stored row count, and drains the three-stage
//   span pipeline before presenting the result. Loading resumes once that drain is
//   done; an overflowed or all-empty matrix skips the walk and reports directly.
// Reset (rst_ni, asynchronous, active low) clears all control state and sets
//   cols_in_use to 32; the row store is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module row_convex_connected_check_top #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rccc_pkg::COLS_W-1:0] cfg_wdata_i,
  rccc_in_if.sink                     in_i,
  rccc_out_if.source                  out_o
);
  import rccc_pkg::*;

  localparam int CntW  = $clog2(MAX_ROWS + 1);
  localparam int AddrW = $clog2(MAX_ROWS);
  localparam int JobW  = 1 + ROW_W + CntW;

  // Row store port signals. The front writes while a matrix loads and the
  // back end reads while it walks; the two never overlap because the front
  // holds off new rows while a job is queued or being walked.
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [ROW_W-1:0] ram_rdata;

  // Job descriptors: final row count, column mask and overflow flag.
  logic             job_push;
  logic [JobW-1:0]  job_in;
  logic [JobW-1:0]  job_head;
  logic             job_pop;
  logic             job_full;
  logic             job_empty;

  logic             back_busy;
  logic             store_busy;

  // The store is owned by the back end from the moment a job is queued until
  // its walk has drained.
  assign store_busy = !job_empty || back_busy;

  rccc_ram #(
    .Width (ROW_W),
    .Depth (MAX_ROWS)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rccc_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .busy_i      (store_busy),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .job_push_o  (job_push),
    .job_o       (job_in)
  );

  rccc_jobq #(
    .Width (JobW),
    .Depth (2)
  ) u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .pop_i   (job_pop),
    .data_o  (job_head),
    .full_o  (job_full),
    .empty_o (job_empty)
  );

  rccc_back #(
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!job_empty),
    .job_i       (job_head),
    .job_pop_o   (job_pop),
    .busy_o      (back_busy),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_o       (out_o)
  );

  // No row may be loaded while the back end walks the store.
  a_no_load_during_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.valid && in_i.ready && back_busy))
    else $error("row item accepted while the row store is being walked");

  // Store write and read ports are never active together.
  a_store_port_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("row store written and read in the same cycle");

  // A job is never pushed into a full queue.
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(job_push && job_full))
    else $error("job pushed into a full queue");

  // Taking a job leads straight to a walk or to a presented result.
  a_pop_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |=> (back_busy || out_o.valid))
    else $error("job taken but back end neither walking nor reporting");

endmodule

// File: design/rccc_ram.sv
// ----------------------------------------------------------------------------
// rccc_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rccc_ram #(
  parameter int Width = 32,
  parameter int Depth = 32,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: design/rccc_jobq.sv
// ----------------------------------------------------------------------------
// rccc_jobq: job queue between the load front and the check back end
// Small FIFO of matrix descriptors (row count, column mask, overflow flag).
// ----------------------------------------------------------------------------
module rccc_jobq #(
  parameter int Width = 8,
  parameter int Depth = 2,
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int CntW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [Width-1:0] entry_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == CntW'(Depth));
  assign empty_o = (fill_q == '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: design/rccc_front.sv
// ----------------------------------------------------------------------------
// rccc_front: row load front
// Masks each accepted row to the columns in use, writes it to the row store,
// tracks the column mask, row count and overflow, and queues a job on the
// last row.
// ----------------------------------------------------------------------------
module rccc_front #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32,
  localparam int CntW  = $clog2(MAX_ROWS + 1),
  localparam int AddrW = $clog2(MAX_ROWS),
  localparam int JobW  = 1 + rccc_pkg::ROW_W + CntW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rccc_pkg::COLS_W-1:0] cfg_wdata_i,
  rccc_in_if.sink                     in_i,
  input  logic                        busy_i,
  output logic                        ram_we_o,
  output logic [AddrW-1:0]            ram_waddr_o,
  output logic [rccc_pkg::ROW_W-1:0]  ram_wdata_o,
  output logic                        job_push_o,
  output logic [JobW-1:0]             job_o
);
  import rccc_pkg::*;

  localparam int ColLim = (MAX_COLS < ROW_W) ? MAX_COLS : ROW_W;

  logic [COLS_W-1:0] cols_q;
  logic [ROW_W-1:0]  used_mask;
  logic [ROW_W-1:0]  row_m;
  logic [ROW_W-1:0]  mask_q, mask_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic              accept, has_room;

  // A column is in use when it is below both the register value and the limit.
  always_comb begin
    for (int j = 0; j < ROW_W; j++) begin
      used_mask[j] = (cols_q > COLS_W'(j)) && (j < ColLim);
    end
  end

  assign in_i.ready = !busy_i;
  assign accept     = in_i.valid && in_i.ready;
  assign row_m      = in_i.row_bits & used_mask;
  assign has_room   = (cnt_q < CntW'(MAX_ROWS));

  always_comb begin
    cnt_d  = cnt_q;
    mask_d = mask_q;
    ovf_d  = ovf_q;
    if (accept) begin
      if (has_room) begin
        cnt_d  = cnt_q + CntW'(1);
        mask_d = mask_q | row_m;
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  assign ram_we_o    = accept && has_room;
  assign ram_waddr_o = cnt_q[AddrW-1:0];
  assign ram_wdata_o = row_m;
  assign job_push_o  = accept && in_i.last_row;
  assign job_o       = {ovf_d, mask_d, cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_RESET;
      cnt_q  <= '0;
      mask_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cols_q <= cfg_wdata_i;
      end
      if (job_push_o) begin
        cnt_q  <= '0;
        mask_q <= '0;
        ovf_q  <= 1'b0;
      end else begin
        cnt_q  <= cnt_d;
        mask_q <= mask_d;
        ovf_q  <= ovf_d;
      end
    end
  end

endmodule

// File: design/rccc_back.sv
// ----------------------------------------------------------------------------
// rccc_back: check back end
// Takes one job, walks the stored rows (unless it overflowed or is all empty)
// through a three-stage pipeline that finds each row's compacted span, and
// presents the verdict until taken.
module rccc_back #(
  parameter int MAX_ROWS = 32,
  localparam int CntW  = $clog2(MAX_ROWS + 1),
  localparam int AddrW = $clog2(MAX_ROWS),
  localparam int JobW  = 1 + rccc_pkg::ROW_W + CntW
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       job_valid_i,
  input  logic [JobW-1:0]            job_i,
  output logic                       job_pop_o,
  output logic                       busy_o,
  output logic                       ram_re_o,
  output logic [AddrW-1:0]           ram_raddr_o,
  input  logic [rccc_pkg::ROW_W-1:0] ram_rdata_i,
  rccc_out_if.source                 out_o
);
  import rccc_pkg::*;

  localparam int KrW = (CntW > KEPT_W) ? CntW : KEPT_W + 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WALK  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic              job_ovf;
  logic [ROW_W-1:0]  job_mask;
  logic [CntW-1:0]   job_cnt;

  logic              ovf_q;
  logic [ROW_W-1:0]  mask_q;
  logic [CntW-1:0]   cnt_q;
  logic [CntW-1:0]   idx_q;
  logic [KEPT_W-1:0] kc_q;

  logic              p1_q, p2_q, p3_q;

  logic [ROW_W-1:0]  low, below, smear, span;
  logic              s1_empty_q, s1_ncvx_q;
  logic [ROW_W-1:0]  s1_mb_q, s1_mu_q;
  logic              s2_empty_q, s2_ncvx_q;
  logic [KEPT_W-1:0] s2_lo_q, s2_cnt_q;

  logic              convex_q, conn_q, have_prev_q;
  logic [KrW-1:0]    kr_q;
  logic [KEPT_W-1:0] prev_lo_q, prev_cnt_q;
  logic              gap, trivial;

  assign job_ovf  = job_i[JobW-1];
  assign job_mask = job_i[JobW-2 -: ROW_W];
  assign job_cnt  = job_i[CntW-1:0];

  always_comb begin
    state_d   = state_q;
    job_pop_o = 1'b0;
    ram_re_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          state_d   = (job_ovf || job_mask == '0) ? S_DONE : S_WALK;
        end
      end
      S_WALK: begin
        ram_re_o = 1'b1;
        if (idx_q == cnt_q - CntW'(1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!p1_q && !p2_q && !p3_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o      = (state_q == S_WALK) || (state_q == S_DRAIN);
  assign ram_raddr_o = idx_q[AddrW-1:0];

  // Stage 1: span of the row in raw columns, and the mask bits below and up
  // to the row's ends. A row is convex when no used column inside its span
  // is clear.
  always_comb begin
    low   = ram_rdata_i & (~ram_rdata_i + ROW_W'(1));
    below = low - ROW_W'(1);
    smear = smear_down(ram_rdata_i);
    span  = smear & ~below;
  end

  // Runs of neighboring rows must overlap or touch in compacted positions.
  assign gap = have_prev_q && ((s2_cnt_q < prev_lo_q) || (s2_lo_q > prev_cnt_q));

  always_ff @(posedge clk_i) begin
    s1_empty_q <= (ram_rdata_i == '0);
    s1_ncvx_q  <= |(span & mask_q & ~ram_rdata_i);
    s1_mb_q    <= mask_q & below;
    s1_mu_q    <= mask_q & smear;
    s2_empty_q <= s1_empty_q;
    s2_ncvx_q  <= s1_ncvx_q;
    s2_lo_q    <= popcount(s1_mb_q);
    s2_cnt_q   <= popcount(s1_mu_q);
    if (job_pop_o) begin
      ovf_q  <= job_ovf;
      mask_q <= job_mask;
      cnt_q  <= job_cnt;
      kc_q   <= popcount(job_mask);
    end
    if (p3_q && !s2_empty_q) begin
      prev_lo_q  <= s2_lo_q;
      prev_cnt_q <= s2_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      p1_q        <= 1'b0;
      p2_q        <= 1'b0;
      p3_q        <= 1'b0;
      convex_q    <= 1'b1;
      conn_q      <= 1'b1;
      have_prev_q <= 1'b0;
      kr_q        <= '0;
    end else begin
      state_q <= state_d;
      p1_q    <= ram_re_o;
      p2_q    <= p1_q;
      p3_q    <= p2_q;
      if (job_pop_o) begin
        idx_q       <= '0;
        convex_q    <= 1'b1;
        conn_q      <= 1'b1;
        have_prev_q <= 1'b0;
        kr_q        <= '0;
      end else begin
        if (ram_re_o) begin
          idx_q <= idx_q + CntW'(1);
        end
        if (p3_q && !s2_empty_q) begin
          kr_q        <= kr_q + KrW'(1);
          have_prev_q <= 1'b1;
          if (s2_ncvx_q) begin
            convex_q <= 1'b0;
          end
          if (gap) begin
            conn_q <= 1'b0;
          end
        end
      end
    end
  end

  assign trivial     = ovf_q || (mask_q == '0);
  assign out_o.valid = (state_q == S_DONE);

  always_comb begin
    priority if (ovf_q) begin
      out_o.status = ST_TOO_MANY_ROWS;
    end else if (mask_q == '0) begin
      out_o.status = ST_ALL_EMPTY;
    end else if (!convex_q) begin
      out_o.status = ST_NOT_CONVEX;
    end else if (!conn_q) begin
      out_o.status = ST_NOT_CONNECTED;
    end else begin
      out_o.status = ST_OK;
    end
  end

  assign out_o.kept_rows = trivial ? '0 :
                           (kr_q > KrW'(KEPT_MAX)) ? KEPT_MAX : kr_q[KEPT_W-1:0];
  assign out_o.kept_cols = trivial ? '0 : kc_q;

endmodule
